>>> rtl/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants of the clamped PID controller
// Widths of the fixed-point datapath, register indexes and the symmetric
// clamp function used by the integral and the drive.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // sample and gain formats
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 16;
    localparam int LIMIT_W        = 31;
    localparam int DRIVE_W        = 32;

    // derived datapath widths
    localparam int ERR_W   = SAMPLE_WIDTH + 1;     // reference - feedback
    localparam int DIFF_W  = ERR_W + 1;            // error - previous error
    localparam int PROD_W  = ERR_W + GAIN_W;       // error * gain
    localparam int DPROD_W = DIFF_W + GAIN_W;      // difference * kd
    // wide enough for P + D + integral + last drive with no overflow
    localparam int ACC_W   = ((DPROD_W > DRIVE_W) ? DPROD_W : DRIVE_W) + 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd5;

    // reset values of the limits
    localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 31'd800;
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 31'd1000;

    // terms of one sample, already scaled down by the gain fraction
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [ACC_W-1:0] p_term;
        logic signed [ACC_W-1:0] i_step;
        logic signed [ACC_W-1:0] d_term;
    } t_terms;

    // clamp x to [-lim, +lim]; the result always fits the drive width
    function automatic logic signed [DRIVE_W-1:0] clamp_sym(
        input logic signed [ACC_W-1:0] x,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = $signed(ACC_W'(lim));
        lo = -hi;
        if (x > hi) begin
            return hi[DRIVE_W-1:0];
        end else if (x < lo) begin
            return lo[DRIVE_W-1:0];
        end
        return x[DRIVE_W-1:0];
    endfunction

endpackage

>>> rtl/pidc_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_terms: error and gain products
// Forms the error and the P, D and integral-step terms, each product
// shifted right arithmetically by the gain fraction (floor rounding).
// ----------------------------------------------------------------------------
module pidc_terms
    import pidc_pkg::*;
(
    input  logic signed [SAMPLE_WIDTH-1:0] i_reference,
    input  logic signed [SAMPLE_WIDTH-1:0] i_feedback,
    input  logic signed [ERR_W-1:0]        i_prev_err,
    input  logic signed [GAIN_W-1:0]       i_kp,
    input  logic signed [GAIN_W-1:0]       i_ki,
    input  logic signed [GAIN_W-1:0]       i_kd,
    output t_terms                         o_terms
);

    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  p_prod;
    logic signed [PROD_W-1:0]  i_prod;
    logic signed [DPROD_W-1:0] d_prod;

    // error and its change since the last sample
    assign err  = ERR_W'(i_reference) - ERR_W'(i_feedback);
    assign diff = DIFF_W'(err) - DIFF_W'(i_prev_err);

    // three independent multiplies
    assign p_prod = PROD_W'(err) * PROD_W'(i_kp);
    assign i_prod = PROD_W'(err) * PROD_W'(i_ki);
    assign d_prod = DPROD_W'(diff) * DPROD_W'(i_kd);

    // drop the gain fraction, rounding toward minus infinity
    always_comb begin
        o_terms.err    = err;
        o_terms.p_term = ACC_W'(p_prod >>> GAIN_FRAC_BITS);
        o_terms.i_step = ACC_W'(i_prod >>> GAIN_FRAC_BITS);
        o_terms.d_term = ACC_W'(d_prod >>> GAIN_FRAC_BITS);
    end

endmodule

>>> rtl/pidc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_accum: loop state and clamps
// Holds previous error, clamped integral and last drive; forms the
// clamped drive of the current sample and updates state on advance.
// ----------------------------------------------------------------------------
module pidc_accum
    import pidc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  t_terms                     i_terms,
    input  logic [LIMIT_W-1:0]         i_int_limit,
    input  logic [LIMIT_W-1:0]         i_out_limit,
    input  logic                       i_accum_mode,
    output logic signed [ERR_W-1:0]    o_prev_err,
    output logic signed [DRIVE_W-1:0]  o_drive
);

    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [DRIVE_W-1:0] r_integral;
    logic signed [DRIVE_W-1:0] r_last_drive;
    logic signed [DRIVE_W-1:0] n_integral;
    logic signed [ACC_W-1:0]   int_sum;
    logic signed [ACC_W-1:0]   pid_sum;
    logic signed [ACC_W-1:0]   raw_drive;

    // integral update with clamp
    assign int_sum    = ACC_W'(r_integral) + i_terms.i_step;
    assign n_integral = clamp_sym(int_sum, i_int_limit);

    // P + D + I, optionally on top of the last drive, then clamp
    assign pid_sum   = i_terms.p_term + i_terms.d_term + ACC_W'(n_integral);
    assign raw_drive = i_accum_mode ? (pid_sum + ACC_W'(r_last_drive)) : pid_sum;
    assign o_drive   = clamp_sym(raw_drive, i_out_limit);

    assign o_prev_err = r_prev_err;

    // state moves only when a sample is handed to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err   <= '0;
            r_integral   <= '0;
            r_last_drive <= '0;
        end else if (i_advance) begin
            r_prev_err   <= i_terms.err;
            r_integral   <= n_integral;
            r_last_drive <= o_drive;
        end
    end

endmodule

>>> rtl/pid_controller_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped: fixed-point PID with integral and output clamp
// A request waits in the input register until its drive is registered in the
// result register; one request per cycle unless the output stalls. Loop state
// closes through multiplies and clamps between input and result registers.
// Reset: loop state zero, gains zero, limits 800 and 1000, mode 0.
// ----------------------------------------------------------------------------
module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [LIMIT_W-1:0]          i_cfg_data,
    // sample channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_reference,
    input  logic signed [SAMPLE_WIDTH-1:0] i_feedback,
    // drive channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DRIVE_W-1:0]   o_drive
);

    logic signed [GAIN_W-1:0]       r_kp;
    logic signed [GAIN_W-1:0]       r_ki;
    logic signed [GAIN_W-1:0]       r_kd;
    logic [LIMIT_W-1:0]             r_int_limit;
    logic [LIMIT_W-1:0]             r_out_limit;
    logic                           r_accum_mode;

    logic                           r_in_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_reference;
    logic signed [SAMPLE_WIDTH-1:0] r_feedback;
    logic                           r_out_vld;
    logic signed [DRIVE_W-1:0]      r_drive;

    logic                           advance;
    logic                           in_take;
    logic signed [ERR_W-1:0]        prev_err;
    logic signed [DRIVE_W-1:0]      drive;
    t_terms                         terms;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= '0;
            r_ki         <= '0;
            r_kd         <= '0;
            r_int_limit  <= INT_LIMIT_RST;
            r_out_limit  <= OUT_LIMIT_RST;
            r_accum_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:        r_kp         <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_KI:        r_ki         <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_KD:        r_kd         <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_INT_LIMIT: r_int_limit  <= i_cfg_data;
                CFG_OUT_LIMIT: r_out_limit  <= i_cfg_data;
                CFG_MODE:      r_accum_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: input register drains into the result register
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_reference <= i_reference;
            r_feedback  <= i_feedback;
        end
        if (advance) begin
            r_drive <= drive;
        end
    end

    // datapath
    pidc_terms u_terms (
        .i_reference (r_reference),
        .i_feedback  (r_feedback),
        .i_prev_err  (prev_err),
        .i_kp        (r_kp),
        .i_ki        (r_ki),
        .i_kd        (r_kd),
        .o_terms     (terms)
    );

    pidc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_terms      (terms),
        .i_int_limit  (r_int_limit),
        .i_out_limit  (r_out_limit),
        .i_accum_mode (r_accum_mode),
        .o_prev_err   (prev_err),
        .o_drive      (drive)
    );

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_drive;

endmodule
